### rtl/cpt_pkg.sv
// Shared package for the collider pair test pipeline.
// Pair kind codes and the control group that travels with each item.
// No dependencies.
package cpt_pkg;

    localparam logic [1:0] OP_BOX_BOX       = 2'd0;
    localparam logic [1:0] OP_BOX_CIRCLE    = 2'd1;
    localparam logic [1:0] OP_CIRCLE_CIRCLE = 2'd2;
    localparam logic [1:0] OP_RESERVED      = 2'd3;   // no test, always a miss

    // Per-item control after the distance test.
    typedef struct packed {
        logic hit;
        logic point_valid;
        logic use_div;      // contact point needs the scaled offset
        logic neg_x;        // offset sign, x axis
        logic neg_y;        // offset sign, y axis
    } t_ctl;

    localparam int CTL_BITS = $bits(t_ctl);

endpackage

### rtl/cpt_geom.sv
// Geometry front end: clamp, differences, squares, products and the distance test.
// Four register stages advanced by a shared enable. Depends on cpt_pkg.
module cpt_geom
    import cpt_pkg::*;
#(
    parameter int CB = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [1:0]             i_operation,
    input  logic signed [CB-1:0]   i_a_x0,
    input  logic signed [CB-1:0]   i_a_y0,
    input  logic signed [CB-1:0]   i_a_x1,
    input  logic signed [CB-1:0]   i_a_y1,
    input  logic signed [CB-1:0]   i_b_x0,
    input  logic signed [CB-1:0]   i_b_y0,
    input  logic signed [CB-1:0]   i_b_x1,
    input  logic signed [CB-1:0]   i_b_y1,
    output logic                   o_valid,
    output t_ctl                   o_ctl,
    output logic [CB-1:0]          o_px,
    output logic [CB-1:0]          o_py,
    output logic [CB-1:0]          o_den,
    output logic [2*CB:0]          o_num_x,
    output logic [2*CB:0]          o_num_y
);

    localparam int DW = CB + 1;
    localparam int NW = DW + CB;

    // ---------------- stage 1 ----------------
    logic                 r1_v;
    logic [1:0]           r1_op;
    logic                 r1_bb;
    logic signed [CB-1:0] r1_nx, r1_ny, r1_bx0, r1_by0, r1_ax0, r1_ay0;
    logic [CB-1:0]        r1_rmag, r1_r1mag;
    logic                 r1_r1neg;
    logic signed [DW-1:0] r1_s, r1_dxc, r1_dyc;

    logic signed [CB-1:0] mn_x, mn_y, n_nx, n_ny;
    logic                 n_bb;

    always_comb begin
        mn_x = (i_b_x0 < i_a_x1) ? i_b_x0 : i_a_x1;
        mn_y = (i_b_y0 < i_a_y1) ? i_b_y0 : i_a_y1;
        n_nx = (i_a_x0 > mn_x) ? i_a_x0 : mn_x;
        n_ny = (i_a_y0 > mn_y) ? i_a_y0 : mn_y;
        n_bb = (i_a_x0 <= i_b_x1) && (i_b_x0 <= i_a_x1) &&
               (i_a_y0 <= i_b_y1) && (i_b_y0 <= i_a_y1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
        if (i_en) begin
            r1_op    <= i_operation;
            r1_bb    <= n_bb;
            r1_nx    <= n_nx;
            r1_ny    <= n_ny;
            r1_bx0   <= i_b_x0;
            r1_by0   <= i_b_y0;
            r1_ax0   <= i_a_x0;
            r1_ay0   <= i_a_y0;
            r1_rmag  <= i_b_x1[CB-1] ? (~i_b_x1 + 1'b1) : i_b_x1;
            r1_r1mag <= i_a_x1[CB-1] ? (~i_a_x1 + 1'b1) : i_a_x1;
            r1_r1neg <= i_a_x1[CB-1];
            r1_s     <= DW'(i_a_x1) + DW'(i_b_x1);
            r1_dxc   <= DW'(i_b_x0) - DW'(i_a_x0);
            r1_dyc   <= DW'(i_b_y0) - DW'(i_a_y0);
        end
    end

    // ---------------- stage 2 ----------------
    logic                 r2_v;
    logic [1:0]           r2_op;
    logic                 r2_bb;
    logic signed [CB-1:0] r2_nx, r2_ny, r2_ax0, r2_ay0;
    logic [DW-1:0]        r2_mx, r2_my, r2_lim;
    logic [CB-1:0]        r2_r1mag, r2_den;
    logic                 r2_negx, r2_negy, r2_sneg, r2_szero;

    logic signed [DW-1:0] dx, dy;

    always_comb begin
        if (r1_op == OP_BOX_CIRCLE) begin
            dx = DW'(r1_bx0) - DW'(r1_nx);
            dy = DW'(r1_by0) - DW'(r1_ny);
        end else begin
            dx = r1_dxc;
            dy = r1_dyc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
        if (i_en) begin
            r2_op    <= r1_op;
            r2_bb    <= r1_bb;
            r2_nx    <= r1_nx;
            r2_ny    <= r1_ny;
            r2_ax0   <= r1_ax0;
            r2_ay0   <= r1_ay0;
            r2_mx    <= dx[DW-1] ? (~dx + 1'b1) : dx;
            r2_my    <= dy[DW-1] ? (~dy + 1'b1) : dy;
            r2_lim   <= (r1_op == OP_BOX_CIRCLE) ? {1'b0, r1_rmag} : r1_s;
            r2_r1mag <= r1_r1mag;
            r2_den   <= r1_s[CB-1:0];
            r2_negx  <= dx[DW-1] ^ r1_r1neg;
            r2_negy  <= dy[DW-1] ^ r1_r1neg;
            r2_sneg  <= r1_s[DW-1];
            r2_szero <= (r1_s == '0);
        end
    end

    // ---------------- stage 3 ----------------
    logic                 r3_v;
    logic [1:0]           r3_op;
    logic                 r3_bb;
    logic signed [CB-1:0] r3_nx, r3_ny, r3_ax0, r3_ay0;
    logic [2*DW-1:0]      r3_sqx, r3_sqy, r3_sql;
    logic [NW-1:0]        r3_numx, r3_numy;
    logic [CB-1:0]        r3_den;
    logic                 r3_negx, r3_negy, r3_sneg, r3_szero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= r2_v;
        end
        if (i_en) begin
            r3_op    <= r2_op;
            r3_bb    <= r2_bb;
            r3_nx    <= r2_nx;
            r3_ny    <= r2_ny;
            r3_ax0   <= r2_ax0;
            r3_ay0   <= r2_ay0;
            r3_sqx   <= r2_mx * r2_mx;
            r3_sqy   <= r2_my * r2_my;
            r3_sql   <= r2_lim * r2_lim;
            r3_numx  <= r2_mx * r2_r1mag;
            r3_numy  <= r2_my * r2_r1mag;
            r3_den   <= r2_den;
            r3_negx  <= r2_negx;
            r3_negy  <= r2_negy;
            r3_sneg  <= r2_sneg;
            r3_szero <= r2_szero;
        end
    end

    // ---------------- stage 4 ----------------
    logic [2*DW:0]        sum;
    t_ctl                 n_ctl;
    logic [CB-1:0]        n_px, n_py;

    always_comb begin
        sum   = (2*DW+1)'(r3_sqx) + (2*DW+1)'(r3_sqy);
        n_ctl = '0;
        n_px  = '0;
        n_py  = '0;
        case (r3_op)
            OP_BOX_BOX: begin
                n_ctl.hit = r3_bb;
            end
            OP_BOX_CIRCLE: begin
                if (sum < (2*DW+1)'(r3_sql)) begin
                    n_ctl.hit         = 1'b1;
                    n_ctl.point_valid = 1'b1;
                    n_px              = r3_nx;
                    n_py              = r3_ny;
                end
            end
            OP_CIRCLE_CIRCLE: begin
                if (!r3_sneg && sum <= (2*DW+1)'(r3_sql)) begin
                    n_ctl.hit         = 1'b1;
                    n_ctl.point_valid = 1'b1;
                    n_ctl.use_div     = !r3_szero;
                    n_ctl.neg_x       = r3_negx;
                    n_ctl.neg_y       = r3_negy;
                    n_px              = r3_ax0;
                    n_py              = r3_ay0;
                end
            end
            default: begin
                n_ctl = '0;
            end
        endcase
    end

    logic r4_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (i_en) begin
            r4_v <= r3_v;
        end
        if (i_en) begin
            o_ctl   <= n_ctl;
            o_px    <= n_px;
            o_py    <= n_py;
            o_den   <= r3_den;
            o_num_x <= r3_numx;
            o_num_y <= r3_numy;
        end
    end

    assign o_valid = r4_v;

endmodule

### rtl/cpt_div.sv
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
// Carries a side vector alongside. No package dependency.
module cpt_div #(
    parameter int CB     = 24,
    parameter int SIDE_W = 53
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [CB-1:0]     i_den,
    input  logic [2*CB:0]     i_num_x,
    input  logic [2*CB:0]     i_num_y,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [CB-1:0]     o_q_x,
    output logic [CB-1:0]     o_q_y,
    output logic [CB:0]       o_rem_x,
    output logic [CB:0]       o_rem_y,
    output logic [CB-1:0]     o_den,
    output logic [SIDE_W-1:0] o_side
);

    localparam int DW = CB + 1;

    logic              r_v    [CB];
    logic [DW-1:0]     r_rx   [CB];
    logic [DW-1:0]     r_ry   [CB];
    logic [CB-1:0]     r_lqx  [CB];   // remaining numerator bits, quotient shifts in
    logic [CB-1:0]     r_lqy  [CB];
    logic [CB-1:0]     r_den  [CB];
    logic [SIDE_W-1:0] r_side [CB];

    for (genvar k = 0; k < CB; k++) begin : g_stage
        logic              v_in;
        logic [DW-1:0]     rx_in, ry_in, tx, ty, n_rx, n_ry;
        logic [CB-1:0]     lqx_in, lqy_in, den_in;
        logic [SIDE_W-1:0] side_in;
        logic              gex, gey;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rx_in   = i_num_x[2*CB:CB];
            assign ry_in   = i_num_y[2*CB:CB];
            assign lqx_in  = i_num_x[CB-1:0];
            assign lqy_in  = i_num_y[CB-1:0];
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign rx_in   = r_rx[k-1];
            assign ry_in   = r_ry[k-1];
            assign lqx_in  = r_lqx[k-1];
            assign lqy_in  = r_lqy[k-1];
            assign den_in  = r_den[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            tx   = {rx_in[CB-1:0], lqx_in[CB-1]};
            ty   = {ry_in[CB-1:0], lqy_in[CB-1]};
            gex  = (tx >= {1'b0, den_in});
            gey  = (ty >= {1'b0, den_in});
            n_rx = gex ? (tx - {1'b0, den_in}) : tx;
            n_ry = gey ? (ty - {1'b0, den_in}) : ty;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
            if (i_en) begin
                r_rx[k]   <= n_rx;
                r_ry[k]   <= n_ry;
                r_lqx[k]  <= {lqx_in[CB-2:0], gex};
                r_lqy[k]  <= {lqy_in[CB-2:0], gey};
                r_den[k]  <= den_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[CB-1];
    assign o_q_x   = r_lqx[CB-1];
    assign o_q_y   = r_lqy[CB-1];
    assign o_rem_x = r_rx[CB-1];
    assign o_rem_y = r_ry[CB-1];
    assign o_den   = r_den[CB-1];
    assign o_side  = r_side[CB-1];

endmodule

### rtl/collider_pair_test.sv
// Collider pair test: box-box, box-circle and circle-circle hit test with contact point.
// Pipeline: four geometry stages, one divider stage per quotient bit, one output stage.
// Throughput one pair per cycle unless the consumer stalls the output.
// The whole pipeline advances together whenever the output register is empty or taken.
// Reset (synchronous, active low) clears every stage valid bit; no other state is kept.
// Depends on cpt_pkg, cpt_geom and cpt_div.
module collider_pair_test
    import cpt_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_operation,
    input  logic signed [COORD_BITS-1:0] i_a_x0,
    input  logic signed [COORD_BITS-1:0] i_a_y0,
    input  logic signed [COORD_BITS-1:0] i_a_x1,
    input  logic signed [COORD_BITS-1:0] i_a_y1,
    input  logic signed [COORD_BITS-1:0] i_b_x0,
    input  logic signed [COORD_BITS-1:0] i_b_y0,
    input  logic signed [COORD_BITS-1:0] i_b_x1,
    input  logic signed [COORD_BITS-1:0] i_b_y1,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_hit,
    output logic                         o_point_valid,
    output logic signed [COORD_BITS-1:0] o_hit_x,
    output logic signed [COORD_BITS-1:0] o_hit_y
);

    localparam int CB     = COORD_BITS;
    localparam int SIDE_W = CTL_BITS + 2 * CB;
    localparam int EW     = CB + 2;   // width of base point plus rounded offset

    // One enable for every stage: advance when the output slot is free or drains.
    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // Front end: clamp, differences, squares, products, distance decision.
    logic          g_valid;
    t_ctl          g_ctl;
    logic [CB-1:0] g_px, g_py, g_den;
    logic [2*CB:0] g_num_x, g_num_y;

    cpt_geom #(.CB(CB)) u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .i_a_x0      (i_a_x0),
        .i_a_y0      (i_a_y0),
        .i_a_x1      (i_a_x1),
        .i_a_y1      (i_a_y1),
        .i_b_x0      (i_b_x0),
        .i_b_y0      (i_b_y0),
        .i_b_x1      (i_b_x1),
        .i_b_y1      (i_b_y1),
        .o_valid     (g_valid),
        .o_ctl       (g_ctl),
        .o_px        (g_px),
        .o_py        (g_py),
        .o_den       (g_den),
        .o_num_x     (g_num_x),
        .o_num_y     (g_num_y)
    );

    // Divide |d| * |r1| by the radius sum; control and base point ride along.
    logic              d_valid;
    logic [CB-1:0]     d_qx, d_qy, d_den;
    logic [CB:0]       d_rx, d_ry;
    logic [SIDE_W-1:0] d_side;

    cpt_div #(.CB(CB), .SIDE_W(SIDE_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (g_valid),
        .i_den   (g_den),
        .i_num_x (g_num_x),
        .i_num_y (g_num_y),
        .i_side  ({g_ctl, g_px, g_py}),
        .o_valid (d_valid),
        .o_q_x   (d_qx),
        .o_q_y   (d_qy),
        .o_rem_x (d_rx),
        .o_rem_y (d_ry),
        .o_den   (d_den),
        .o_side  (d_side)
    );

    // Output stage: round half away from zero, apply sign, add to first center, saturate.
    t_ctl                 f_ctl;
    logic signed [CB-1:0] f_px, f_py;
    logic [CB:0]          qrx, qry;
    logic signed [EW-1:0] ex, ey;
    logic signed [CB-1:0] n_hx, n_hy;

    localparam logic signed [EW-1:0] SAT_MAX = EW'({1'b0, {(CB-1){1'b1}}});
    localparam logic signed [EW-1:0] SAT_MIN = -SAT_MAX - EW'(1);

    always_comb begin
        f_ctl = d_side[SIDE_W-1 -: CTL_BITS];
        f_px  = d_side[2*CB-1 -: CB];
        f_py  = d_side[CB-1:0];
        // round up when twice the remainder reaches the divisor
        qrx = (CB+1)'(d_qx) + (CB+1)'({d_rx[CB-1:0], 1'b0} >= {1'b0, d_den});
        qry = (CB+1)'(d_qy) + (CB+1)'({d_ry[CB-1:0], 1'b0} >= {1'b0, d_den});
        ex  = EW'(f_px) + (f_ctl.neg_x ? -EW'(qrx) : EW'(qrx));
        ey  = EW'(f_py) + (f_ctl.neg_y ? -EW'(qry) : EW'(qry));
        n_hx = f_px;
        n_hy = f_py;
        if (f_ctl.use_div) begin
            n_hx = (ex > SAT_MAX) ? SAT_MAX[CB-1:0] :
                   (ex < SAT_MIN) ? SAT_MIN[CB-1:0] : ex[CB-1:0];
            n_hy = (ey > SAT_MAX) ? SAT_MAX[CB-1:0] :
                   (ey < SAT_MIN) ? SAT_MIN[CB-1:0] : ey[CB-1:0];
        end
    end

    logic r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= d_valid;
        end
        // hold the result while the consumer stalls
        if (en) begin
            o_hit         <= f_ctl.hit;
            o_point_valid <= f_ctl.point_valid;
            o_hit_x       <= n_hx;
            o_hit_y       <= n_hy;
        end
    end

    assign o_valid = r_out_v;

endmodule

### rtl/cpt_checker.sv
// Port-level checks for collider_pair_test, attached by bind.
// Depends only on the top level's ports.
module cpt_checker #(
    parameter int COORD_BITS = 24
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_ready,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic                  o_hit,
    input logic                  o_point_valid,
    input logic [COORD_BITS-1:0] o_hit_x,
    input logic [COORD_BITS-1:0] o_hit_y
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hit) && $stable(o_hit_x)
                                && $stable(o_hit_y) && $stable(o_point_valid))
        else $error("result changed while stalled");

    // an empty output slot never blocks the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with empty output");

    a_point_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_point_valid |-> o_hit)
        else $error("contact point without hit");

    a_zero_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_point_valid |-> o_hit_x == '0 && o_hit_y == '0)
        else $error("nonzero point without contact");

endmodule

bind collider_pair_test cpt_checker #(.COORD_BITS(COORD_BITS)) u_cpt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_hit         (o_hit),
    .o_point_valid (o_point_valid),
    .o_hit_x       (o_hit_x),
    .o_hit_y       (o_hit_y)
);
